// ----- hw/rtl/caption_cdp_framer_assert.svh -----
// Assertion macros for the caption CDP framer checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef CAPTION_CDP_FRAMER_ASSERT_SVH
`define CAPTION_CDP_FRAMER_ASSERT_SVH

// Checked at every rising edge outside reset.
`define CCF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CCF_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ccf_pkg.sv -----
// Shared types, constants and the microcode table of the caption CDP framer.
// No dependencies.
`timescale 1ns / 1ps

package ccf_pkg;

	localparam int unsigned MAX_TRIPLES_DEF = 31;
	localparam int unsigned STEP_W = 5;
	localparam int unsigned SEQ_W = 16;
	localparam int unsigned RATE_W = 4;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [7:0] CDP_ID_HI = 8'h96;
	localparam logic [7:0] CDP_ID_LO = 8'h69;
	localparam logic [7:0] CDP_LEN_BASE = 8'd13;
	localparam logic [7:0] CDP_FLAGS = 8'h40 | 8'h02 | 8'h01;
	localparam logic [7:0] CDP_SEC_DATA = 8'h72;
	localparam logic [7:0] CDP_SEC_FOOT = 8'h74;
	localparam logic [7:0] CDP_CNT_MASK = 8'h1F;
	localparam logic [7:0] CDP_CNT_MARK = 8'hE0;
	localparam logic [7:0] CDP_HDR_MARK = 8'hF8;
	localparam logic [RATE_W-1:0] RATE_RESET = 4'd4;

	typedef enum logic {
		REG_FRAME_RATE = 1'b0,
		REG_INIT_SEQ   = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		SRC_ID_HI,
		SRC_ID_LO,
		SRC_LEN,
		SRC_RATE,
		SRC_FLAGS,
		SRC_SEQ_HI,
		SRC_SEQ_LO,
		SRC_SEC_DATA,
		SRC_CNT,
		SRC_T_HDR,
		SRC_T_D1,
		SRC_T_D2,
		SRC_SEC_FOOT,
		SRC_CSUM
	} byte_src_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_EMPTY,
		JMP_MORE
	} jmp_t;

	typedef struct packed {
		byte_src_t         src;
		logic              emit;
		logic              fetch;
		logic              last;
		jmp_t              jmp;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic empty;
		logic more;
	} store_stat_t;

	localparam logic [STEP_W-1:0] STEP_FETCH = 5'd9;
	localparam logic [STEP_W-1:0] STEP_FOOT = 5'd13;

	// Program: nine header bytes, a fetch plus three bytes per triple, footer.
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w.src = SRC_ID_HI;
		w.emit = 1'b1;
		w.fetch = 1'b0;
		w.last = 1'b0;
		w.jmp = JMP_NONE;
		w.target = '0;
		unique case (step)
			5'd0: w.src = SRC_ID_HI;
			5'd1: w.src = SRC_ID_LO;
			5'd2: w.src = SRC_LEN;
			5'd3: w.src = SRC_RATE;
			5'd4: w.src = SRC_FLAGS;
			5'd5: w.src = SRC_SEQ_HI;
			5'd6: w.src = SRC_SEQ_LO;
			5'd7: w.src = SRC_SEC_DATA;
			5'd8: begin
				w.src = SRC_CNT;
				w.jmp = JMP_EMPTY;
				w.target = STEP_FOOT;
			end
			5'd9: begin
				w.emit = 1'b0;
				w.fetch = 1'b1;
			end
			5'd10: w.src = SRC_T_HDR;
			5'd11: w.src = SRC_T_D1;
			5'd12: begin
				w.src = SRC_T_D2;
				w.jmp = JMP_MORE;
				w.target = STEP_FETCH;
			end
			5'd13: w.src = SRC_SEC_FOOT;
			5'd14: w.src = SRC_SEQ_HI;
			5'd15: w.src = SRC_SEQ_LO;
			5'd16: begin
				w.src = SRC_CSUM;
				w.last = 1'b1;
			end
			default: begin
				w.emit = 1'b0;
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- hw/rtl/ccf_sequencer.sv -----
// Step counter and microcode fetch for the caption CDP framer.
// Depends on ccf_pkg (ucode_rom, ucode_t, store_stat_t).
`timescale 1ns / 1ps

module ccf_sequencer import ccf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        go,
	input  store_stat_t stat,
	output logic        running,
	output ucode_t      cw
);

	logic              running_q;
	logic [STEP_W-1:0] step_q;
	logic              taken;

	assign cw = ucode_rom(step_q);
	assign running = running_q;

	always_comb begin
		unique case (cw.jmp)
			JMP_EMPTY: taken = stat.empty;
			JMP_MORE:  taken = stat.more;
			default:   taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			running_q <= 1'b1;
			step_q <= '0;
		end else if (go) begin
			if (cw.last) begin
				running_q <= 1'b0;
				step_q <= '0;
			end else begin
				step_q <= taken ? cw.target : step_q + STEP_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/ccf_store.sv -----
// Triple store, fill count and overflow flag of the caption CDP framer.
// Depends on ccf_pkg (ucode_t, store_stat_t, CDP_HDR_MARK).
`timescale 1ns / 1ps

module ccf_store import ccf_pkg::*; #(
	parameter int unsigned MAX_TRIPLES = MAX_TRIPLES_DEF,
	localparam int unsigned CNT_W = $clog2(MAX_TRIPLES + 1),
	localparam int unsigned ADDR_W = (MAX_TRIPLES > 1) ? $clog2(MAX_TRIPLES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_req,
	input  logic [7:0]       cc_header,
	input  logic [7:0]       cc_first_data,
	input  logic [7:0]       cc_second_data,
	input  logic             go,
	input  ucode_t           cw,
	output logic [CNT_W-1:0] count,
	output logic             overflow,
	output logic [23:0]      rd_data,
	output store_stat_t      stat
);

	logic [23:0]      mem [MAX_TRIPLES];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic             overflow_q;
	logic [23:0]      rd_q;
	logic             full;

	assign full = (count_q == CNT_W'(MAX_TRIPLES));
	assign count = count_q;
	assign overflow = overflow_q;
	assign rd_data = rd_q;
	assign stat.empty = (count_q == '0);
	assign stat.more = (idx_q != count_q);

	always_ff @(posedge clk) begin
		if (wr_req && !full) begin
			mem[count_q[ADDR_W-1:0]] <= {cc_header | CDP_HDR_MARK, cc_first_data,
				cc_second_data};
		end
		if (go && cw.fetch) begin
			rd_q <= mem[idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
			overflow_q <= 1'b0;
		end else if (go && cw.last) begin
			count_q <= '0;
			idx_q <= '0;
			overflow_q <= 1'b0;
		end else begin
			if (wr_req) begin
				// drop the triple once the store is full
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (go && cw.fetch) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/ccf_datapath.sv -----
// Byte selection, checksum, sequence count and word packing of the CDP framer.
// Depends on ccf_pkg (ucode_t, byte_src_t, reg_idx_t, packet constants).
`timescale 1ns / 1ps

module ccf_datapath import ccf_pkg::*; #(
	parameter int unsigned CNT_W = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  go,
	input  ucode_t                cw,
	input  logic [CNT_W-1:0]      count,
	input  logic                  overflow,
	input  logic [23:0]           rd_data,
	output logic                  hold,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte0,
	output logic [7:0]            out_byte1,
	output logic [7:0]            out_byte2,
	output logic [7:0]            out_byte3,
	output logic [2:0]            byte_count,
	output logic                  last_word,
	output logic                  was_truncated
);

	logic [RATE_W-1:0] rate_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [7:0]        sum_q;
	logic [1:0]        pos_q;
	logic [7:0]        wbuf_q [3];
	logic              out_valid_q;
	logic [7:0]        obyte_q [4];
	logic [2:0]        ocnt_q;
	logic              olast_q;
	logic              otrunc_q;
	logic [7:0]        cur;
	logic              completes;
	logic              push;
	logic [7:0]        word [4];

	always_comb begin
		unique case (cw.src)
			SRC_ID_HI:    cur = CDP_ID_HI;
			SRC_ID_LO:    cur = CDP_ID_LO;
			SRC_LEN:      cur = CDP_LEN_BASE + 8'(count) * 8'd3;
			SRC_RATE:     cur = {rate_q, 4'hF};
			SRC_FLAGS:    cur = CDP_FLAGS;
			SRC_SEQ_HI:   cur = seq_q[15:8];
			SRC_SEQ_LO:   cur = seq_q[7:0];
			SRC_SEC_DATA: cur = CDP_SEC_DATA;
			SRC_CNT:      cur = (8'(count) & CDP_CNT_MASK) | CDP_CNT_MARK;
			SRC_T_HDR:    cur = rd_data[23:16];
			SRC_T_D1:     cur = rd_data[15:8];
			SRC_T_D2:     cur = rd_data[7:0];
			SRC_SEC_FOOT: cur = CDP_SEC_FOOT;
			SRC_CSUM:     cur = 8'd0 - sum_q;
			default:      cur = 8'd0;
		endcase
	end

	assign completes = cw.emit && ((pos_q == 2'd3) || cw.last);
	// hold the program while a finished word has nowhere to go
	assign hold = completes && out_valid_q && !out_ready;
	assign push = go && completes;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (2'(j) == pos_q) begin
				word[j] = cur;
			end else if (j < 3 && 2'(j) < pos_q) begin
				word[j] = wbuf_q[j % 3];
			end else begin
				word[j] = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			seq_q <= '0;
			sum_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write && cfg_index == REG_FRAME_RATE) begin
				rate_q <= cfg_data[RATE_W-1:0];
			end
			if (cfg_write && cfg_index == REG_INIT_SEQ) begin
				seq_q <= cfg_data[SEQ_W-1:0];
			end else if (go && cw.last) begin
				seq_q <= seq_q + SEQ_W'(1);
			end
			if (go && cw.emit) begin
				sum_q <= cw.last ? 8'd0 : sum_q + cur;
				pos_q <= completes ? 2'd0 : pos_q + 2'd1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && cw.emit && !completes) begin
			for (int j = 0; j < 3; j++) begin
				if (2'(j) == pos_q) begin
					wbuf_q[j] <= cur;
				end
			end
		end
		if (push) begin
			for (int j = 0; j < 4; j++) begin
				obyte_q[j] <= word[j];
			end
			ocnt_q <= {1'b0, pos_q} + 3'd1;
			olast_q <= cw.last;
			otrunc_q <= overflow;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte0 = obyte_q[0];
	assign out_byte1 = obyte_q[1];
	assign out_byte2 = obyte_q[2];
	assign out_byte3 = obyte_q[3];
	assign byte_count = ocnt_q;
	assign last_word = olast_q;
	assign was_truncated = otrunc_q;

endmodule

// ----- hw/rtl/caption_cdp_framer.sv -----
// Caption CDP framer: an accepted request stores its triple if has_triple is set.
// A request with end_of_packet starts the microcode, which emits one byte a cycle
// while the output does not stall; each store read takes a fetch step with no byte.
// in_ready stays low while a packet is emitted, longer when stalls hold the microcode.
// Reset clears control state and sets the rate code to 4 and the sequence count to 0.
`timescale 1ns / 1ps

module caption_cdp_framer import ccf_pkg::*; #(
	parameter int unsigned MAX_TRIPLES = MAX_TRIPLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  has_triple,
	input  logic [7:0]            cc_header,
	input  logic [7:0]            cc_first_data,
	input  logic [7:0]            cc_second_data,
	input  logic                  end_of_packet,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte0,
	output logic [7:0]            out_byte1,
	output logic [7:0]            out_byte2,
	output logic [7:0]            out_byte3,
	output logic [2:0]            byte_count,
	output logic                  last_word,
	output logic                  was_truncated
);

	localparam int unsigned CNT_W = $clog2(MAX_TRIPLES + 1);

	logic             in_acc;
	logic             running;
	logic             hold;
	logic             go;
	ucode_t           cw;
	store_stat_t      stat;
	logic [CNT_W-1:0] count;
	logic             overflow;
	logic [23:0]      rd_data;

	assign in_ready = !running;
	assign in_acc = in_valid && in_ready;
	assign go = running && !hold;

	ccf_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_acc && end_of_packet),
		.go      (go),
		.stat    (stat),
		.running (running),
		.cw      (cw)
	);

	ccf_store #(
		.MAX_TRIPLES (MAX_TRIPLES)
	) u_store (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_req         (in_acc && has_triple),
		.cc_header      (cc_header),
		.cc_first_data  (cc_first_data),
		.cc_second_data (cc_second_data),
		.go             (go),
		.cw             (cw),
		.count          (count),
		.overflow       (overflow),
		.rd_data        (rd_data),
		.stat           (stat)
	);

	ccf_datapath #(
		.CNT_W (CNT_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.go            (go),
		.cw            (cw),
		.count         (count),
		.overflow      (overflow),
		.rd_data       (rd_data),
		.hold          (hold),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte0     (out_byte0),
		.out_byte1     (out_byte1),
		.out_byte2     (out_byte2),
		.out_byte3     (out_byte3),
		.byte_count    (byte_count),
		.last_word     (last_word),
		.was_truncated (was_truncated)
	);

endmodule

// ----- hw/rtl/ccf_checker.sv -----
// Port-level checks of the caption CDP framer, bound to the top level.
// Depends on caption_cdp_framer_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "caption_cdp_framer_assert.svh"

module ccf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte0,
	input logic [2:0] byte_count,
	input logic       last_word
);

	`CCF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte0) && $stable(byte_count) && $stable(last_word), "stalled word changed")
	`CCF_ASSERT(a_count_range, out_valid |-> byte_count != 3'd0 && byte_count <= 3'd4, "byte_count out of range")
	`CCF_ASSERT(a_full_words, out_valid && !last_word |-> byte_count == 3'd4, "short word before packet end")
	`CCF_ASSERT(a_busy_mid_packet, out_valid && !last_word |-> !in_ready, "request taken mid packet")
	`CCF_ASSERT_RST(a_reset_idle, !arst_n |-> !out_valid && in_ready, "not idle in reset")

endmodule

bind caption_cdp_framer ccf_checker u_ccf_checker (.*);

// ----- tb/caption_cdp_framer_test.sv -----
// Self-checking testbench for the caption CDP framer: queues caption requests,
// predicts every packet word at request acceptance and checks the word stream.
// Depends on ccf_pkg and caption_cdp_framer.
`timescale 1ns / 1ps

module caption_cdp_framer_test;
	import ccf_pkg::*;

	localparam int unsigned IDLE_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned REQUEST_TARGET = 460;

	typedef struct packed {
		logic       has_triple;
		logic [7:0] header;
		logic [7:0] first_data;
		logic [7:0] second_data;
		logic       eop;
	} caption_req_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
		logic            last;
		logic            truncated;
	} cdp_word_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	reg_idx_t              cfg_index = REG_FRAME_RATE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  has_triple = 1'b0;
	logic [7:0]            cc_header = '0;
	logic [7:0]            cc_first_data = '0;
	logic [7:0]            cc_second_data = '0;
	logic                  end_of_packet = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            out_byte0;
	logic [7:0]            out_byte1;
	logic [7:0]            out_byte2;
	logic [7:0]            out_byte3;
	logic [2:0]            byte_count;
	logic                  last_word;
	logic                  was_truncated;

	// Framer state as the predictor sees it
	logic [RATE_W-1:0] rate_code = RATE_RESET;
	logic [SEQ_W-1:0]  seq_count = '0;
	logic [23:0]       held_triples [MAX_TRIPLES_DEF];
	int unsigned       held_count = 0;
	logic              dropped_any = 1'b0;

	caption_req_t caption_requests [$];
	cdp_word_t    cdp_words_due [$];
	caption_req_t driven_req;
	int           err_count = 0;
	int unsigned  requests_counted = 0;
	int unsigned  send_gap = 0;
	int unsigned  sink_stall = 0;
	int unsigned  idle_cycles = 0;
	logic         sender_steady = 1'b0;
	logic         sink_steady = 1'b0;

	caption_cdp_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.has_triple(has_triple),
		.cc_header(cc_header),
		.cc_first_data(cc_first_data),
		.cc_second_data(cc_second_data),
		.end_of_packet(end_of_packet),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte0(out_byte0),
		.out_byte1(out_byte1),
		.out_byte2(out_byte2),
		.out_byte3(out_byte3),
		.byte_count(byte_count),
		.last_word(last_word),
		.was_truncated(was_truncated)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Store the triple of an accepted request; on packet end, frame the CDP into words
	task automatic absorb_request(input caption_req_t r);
		logic [7:0]  pkt [0:127];
		logic [7:0]  byte_sum;
		int unsigned n, len, i, j, k;
		cdp_word_t   w;
		if (r.has_triple) begin
			if (held_count < MAX_TRIPLES_DEF) begin
				held_triples[held_count] = {r.header | CDP_HDR_MARK, r.first_data, r.second_data};
				held_count++;
			end else begin
				dropped_any = 1'b1;
			end
		end
		if (r.eop) begin
			n = held_count;
			pkt[0] = CDP_ID_HI;
			pkt[1] = CDP_ID_LO;
			pkt[2] = CDP_LEN_BASE + 8'(3 * n);
			pkt[3] = {rate_code, 4'hF};
			pkt[4] = CDP_FLAGS;
			pkt[5] = seq_count[15:8];
			pkt[6] = seq_count[7:0];
			pkt[7] = CDP_SEC_DATA;
			pkt[8] = CDP_CNT_MARK | (CDP_CNT_MASK & 8'(n));
			for (i = 0; i < n; i++) begin
				pkt[9 + 3 * i] = held_triples[i][23:16];
				pkt[10 + 3 * i] = held_triples[i][15:8];
				pkt[11 + 3 * i] = held_triples[i][7:0];
			end
			len = 9 + 3 * n;
			pkt[len] = CDP_SEC_FOOT;
			pkt[len + 1] = seq_count[15:8];
			pkt[len + 2] = seq_count[7:0];
			byte_sum = '0;
			for (i = 0; i < len + 3; i++)
				byte_sum = byte_sum + pkt[i];
			pkt[len + 3] = -byte_sum;
			len = len + 4;
			for (k = 0; k < len; k += 4) begin
				w = '0;
				for (j = 0; j < 4; j++)
					if (k + j < len)
						w.bytes[j] = pkt[k + j];
				w.count = (len - k > 4) ? 3'd4 : 3'(len - k);
				w.last = (k + 4 >= len);
				w.truncated = dropped_any;
				cdp_words_due.push_back(w);
			end
			seq_count = seq_count + 1'b1;
			held_count = 0;
			dropped_any = 1'b0;
		end
	endtask

	task automatic queue_request(input logic triple, input logic [7:0] hdr,
			input logic [7:0] d1, input logic [7:0] d2, input logic eop);
		caption_req_t r;
		r = '{has_triple: triple, header: hdr, first_data: d1, second_data: d2, eop: eop};
		caption_requests.push_back(r);
		if (triple || eop)
			requests_counted++;
	endtask

	// A packet of n triples with random content, sprinkled with ignored requests
	task automatic queue_packet(input int unsigned n);
		int unsigned i, body;
		logic        ride;
		ride = (n > 0) && ($urandom_range(0, 1) == 1);
		body = ride ? n - 1 : n;
		for (i = 0; i < body; i++) begin
			if ($urandom_range(0, 19) == 0)
				queue_request(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
			queue_request(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
		end
		queue_request(ride, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
	endtask

	task automatic queue_random_packet();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			queue_packet($urandom_range(0, 4));
		else if (r < 85)
			queue_packet($urandom_range(5, 12));
		else if (r < 95)
			queue_packet($urandom_range(13, 31));
		else
			queue_packet($urandom_range(31, 35));
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_FRAME_RATE)
			rate_code = value[RATE_W-1:0];
		else
			seq_count = value;
	endtask

	// Hold until every queued request is taken and every word has come out
	task automatic wait_idle();
		do
			@(negedge clk);
		while (caption_requests.size() != 0 || in_valid || cdp_words_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : source
		caption_req_t req;
		logic         valid_next;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			valid_next = in_valid;
			if (in_valid && in_ready) begin
				absorb_request(driven_req);
				valid_next = 1'b0;
			end
			if (!valid_next) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (caption_requests.size() > 0) begin
					req = caption_requests.pop_front();
					has_triple <= req.has_triple;
					cc_header <= req.header;
					cc_first_data <= req.first_data;
					cc_second_data <= req.second_data;
					end_of_packet <= req.eop;
					driven_req = req;
					valid_next = 1'b1;
					send_gap = sender_steady ? 0 : pick_gap();
				end
			end
			in_valid <= valid_next;
		end
	end

	always @(posedge clk) begin : sink
		cdp_word_t       want;
		logic [3:0][7:0] got;
		logic            ready_next;
		int              j;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = {out_byte3, out_byte2, out_byte1, out_byte0};
				if (cdp_words_due.size() == 0) begin
					$error("unexpected word: bytes %h count %0d last %b", got, byte_count,
						last_word);
					err_count++;
				end else begin
					want = cdp_words_due.pop_front();
					for (j = 0; j < 4; j++)
						if (got[j] !== want.bytes[j]) begin
							$error("out_byte%0d: expected %h, got %h", j, want.bytes[j], got[j]);
							err_count++;
						end
					if (byte_count !== want.count) begin
						$error("byte_count: expected %0d, got %0d", want.count, byte_count);
						err_count++;
					end
					if (last_word !== want.last) begin
						$error("last_word: expected %b, got %b", want.last, last_word);
						err_count++;
					end
					if (was_truncated !== want.truncated) begin
						$error("was_truncated: expected %b, got %b", want.truncated,
							was_truncated);
						err_count++;
					end
				end
			end
			if (sink_steady) begin
				ready_next = 1'b1;
			end else if (sink_stall > 0) begin
				sink_stall--;
				ready_next = 1'b0;
			end else begin
				sink_stall = pick_gap();
				ready_next = (sink_stall == 0);
				if (sink_stall > 0)
					sink_stall--;
			end
			out_ready <= ready_next;
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned      p;
		logic [11:0]      upper;
		logic [RATE_W-1:0] rate;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: empty packet, single triple, extreme bytes, ignored request
		queue_request(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		queue_request(1'b1, 8'h00, 8'h00, 8'h00, 1'b1);
		queue_request(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		queue_request(1'b1, 8'h07, 8'hAA, 8'h55, 1'b0);
		queue_request(1'b0, 8'h5A, 8'hC3, 8'h3C, 1'b0);
		queue_request(1'b0, 8'h00, 8'h00, 8'h00, 1'b1);
		queue_request(1'b1, 8'hF8, 8'h80, 8'h01, 1'b1);
		wait_idle();

		// Rate code zero with high bits set, sequence wrap
		write_reg(REG_FRAME_RATE, 16'hFFF0);
		write_reg(REG_INIT_SEQ, 16'hFFFF);
		queue_request(1'b0, 8'h00, 8'h00, 8'h00, 1'b1);
		queue_request(1'b0, 8'h00, 8'h00, 8'h00, 1'b1);
		queue_request(1'b1, 8'h80, 8'h7F, 8'hFE, 1'b1);
		wait_idle();

		// Full store, then overflow by two and by one triple, on a middle or the end request
		write_reg(REG_FRAME_RATE, 16'h000F);
		queue_packet(MAX_TRIPLES_DEF);
		queue_packet(MAX_TRIPLES_DEF + 2);
		queue_packet(MAX_TRIPLES_DEF + 1);
		wait_idle();

		p = 0;
		while (requests_counted < REQUEST_TARGET) begin
			case (p % 6)
				0: rate = 4'd1;
				1: rate = 4'd8;
				2: rate = 4'd0;
				3: rate = 4'd15;
				4: rate = 4'd9;
				default: rate = 4'($urandom_range(0, 15));
			endcase
			upper = 12'($urandom);
			write_reg(REG_FRAME_RATE, {upper, rate});
			if (p % 3 != 2) begin
				case (p % 4)
					0: write_reg(REG_INIT_SEQ, 16'hFFFE);
					1: write_reg(REG_INIT_SEQ, 16'h0000);
					default: write_reg(REG_INIT_SEQ, 16'($urandom));
				endcase
			end
			sender_steady = (p % 4 == 1);
			sink_steady = (p % 4 == 2);
			repeat ($urandom_range(4, 9)) queue_random_packet();
			wait_idle();
			p++;
		end

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- caption_cdp_framer.f -----
+incdir+hw/rtl
hw/rtl/ccf_pkg.sv
hw/rtl/ccf_sequencer.sv
hw/rtl/ccf_store.sv
hw/rtl/ccf_datapath.sv
hw/rtl/caption_cdp_framer.sv
hw/rtl/ccf_checker.sv
tb/caption_cdp_framer_test.sv
